// ===== rtl/pgtt_pkg.sv =====
package pgtt_pkg;

  localparam int NUM_GAINS = 3;
  localparam int GAIN_W    = 32;
  localparam int STEP_W    = 31;
  localparam int SQ_W      = 31;
  localparam int OUT_SUM_W = 48;
  localparam int TICK_W    = 16;
  localparam int CFG_W     = 32;
  localparam int ADDR_W    = 5;

  // gain under trial
  localparam logic [1:0] GAIN_P = 2'd0;
  localparam logic [1:0] GAIN_I = 2'd1;
  localparam logic [1:0] GAIN_D = 2'd2;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_PLUS  = 2'd1,
    PH_MINUS = 2'd2
  } phase_t;

  // register indexes
  localparam logic [2:0] REG_WINDOW_LENGTH  = 3'd0;
  localparam logic [2:0] REG_INITIAL_KP     = 3'd1;
  localparam logic [2:0] REG_INITIAL_KI     = 3'd2;
  localparam logic [2:0] REG_INITIAL_KD     = 3'd3;
  localparam logic [2:0] REG_INITIAL_STEP_P = 3'd4;
  localparam logic [2:0] REG_INITIAL_STEP_I = 3'd5;
  localparam logic [2:0] REG_INITIAL_STEP_D = 3'd6;

  // reset values, gains and steps in q8.24
  localparam logic [TICK_W-1:0]        WL_RESET     = 16'd50;
  localparam logic signed [GAIN_W-1:0] KP_RESET     = 32'sd3355443;
  localparam logic signed [GAIN_W-1:0] KI_RESET     = 32'sd67109;
  localparam logic signed [GAIN_W-1:0] KD_RESET     = 32'sd50331648;
  localparam logic [STEP_W-1:0]        STEP_P_RESET = 31'd3355443;
  localparam logic [STEP_W-1:0]        STEP_I_RESET = 31'd67109;
  localparam logic [STEP_W-1:0]        STEP_D_RESET = 31'd16777216;

  localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;
  localparam logic [STEP_W-1:0] STEP_MAX = 31'h7FFF_FFFF;

  // ceil(2^37 / 5): exact floor(y / 5) for any 34-bit y
  localparam logic [34:0] DIV5_MAGIC = 35'd27487790695;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            win_end;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              is_step;
    logic [1:0]        idx;
    logic [CFG_W-1:0]  value;
  } cfg_load_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        idx;
    logic [STEP_W-1:0] value;
  } step_wb_t;

endpackage

// ===== rtl/pgtt_front.sv =====
module pgtt_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [15:0]         in_track_error,
  input  logic [15:0]                window_length,
  input  logic                       q_full,
  output logic                       q_push,
  output pgtt_pkg::item_t            q_item
);
  import pgtt_pkg::*;

  logic [TICK_W-1:0]   tick_r;
  logic [TICK_W-1:0]   tick_nxt;
  logic signed [31:0]  square;
  logic                win_end;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign square  = 32'(in_track_error) * 32'(in_track_error);
  assign win_end = (window_length != '0) && (tick_r >= window_length);

  assign q_item.sq      = square[SQ_W-1:0];
  assign q_item.win_end = win_end;

  always_comb begin
    tick_nxt = tick_r;
    if (q_push) begin
      if (win_end) begin
        tick_nxt = TICK_W'(1);
      end else if (tick_r != TICK_MAX) begin
        tick_nxt = tick_r + TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else begin
      tick_r <= tick_nxt;
    end
  end

endmodule

// ===== rtl/pgtt_queue.sv =====
module pgtt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pgtt_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output pgtt_pkg::item_t  head_item
);
  import pgtt_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/pgtt_scaler.sv =====
module pgtt_scaler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          idx,
  input  logic                up,
  input  logic [30:0]         step,
  output pgtt_pkg::step_wb_t  wb
);
  import pgtt_pkg::*;

  logic [34:0] scaled;
  logic [33:0] half;
  logic [51:0] ph_r;
  logic [51:0] pl_r;
  logic [1:0]  idx_r;
  logic        valid_r;
  logic [68:0] product;
  logic [31:0] quot;

  // step*11 + 5 or step*9 + 5, then /10 as (x>>1)/5
  always_comb begin
    if (up) begin
      scaled = {1'b0, step, 3'b000} + {3'b000, step, 1'b0} + 35'(step) + 35'd5;
    end else begin
      scaled = {1'b0, step, 3'b000} + 35'(step) + 35'd5;
    end
  end

  assign half = scaled[34:1];

  always_ff @(posedge clk) begin
    if (start) begin
      ph_r  <= 52'(half[33:17]) * 52'(DIV5_MAGIC);
      pl_r  <= 52'(half[16:0]) * 52'(DIV5_MAGIC);
      idx_r <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= start;
    end
  end

  assign product  = {ph_r, 17'b0} + 69'(pl_r);
  assign quot     = product[68:37];

  assign wb.valid = valid_r;
  assign wb.idx   = idx_r;
  assign wb.value = quot[31] ? STEP_MAX : quot[30:0];

endmodule

// ===== rtl/pgtt_back.sv =====
module pgtt_back #(
  parameter int SUM_WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  pgtt_pkg::item_t      q_item,
  output logic                 q_pop,
  input  pgtt_pkg::cfg_load_t  cfg_ld,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_gain_p,
  output logic signed [31:0]   out_gain_i,
  output logic signed [31:0]   out_gain_d,
  output logic                 out_window_end,
  output logic [47:0]          out_best_error,
  output logic [1:0]           out_gain_index,
  output logic [1:0]           out_trial_phase
);
  import pgtt_pkg::*;

  function automatic logic signed [GAIN_W-1:0] sat_add(
    input logic signed [GAIN_W-1:0] g,
    input logic signed [GAIN_W+1:0] d
  );
    logic signed [GAIN_W+1:0] s;
    s = {{2{g[GAIN_W-1]}}, g} + d;
    if (s[GAIN_W+1:GAIN_W-1] == 3'b000 || s[GAIN_W+1:GAIN_W-1] == 3'b111) begin
      sat_add = s[GAIN_W-1:0];
    end else if (s[GAIN_W+1]) begin
      sat_add = {1'b1, {(GAIN_W-1){1'b0}}};
    end else begin
      sat_add = {1'b0, {(GAIN_W-1){1'b1}}};
    end
  endfunction

  logic signed [GAIN_W-1:0] gain_r   [NUM_GAINS];
  logic signed [GAIN_W-1:0] gain_nxt [NUM_GAINS];
  logic signed [GAIN_W-1:0] gain_inc [NUM_GAINS];
  logic signed [GAIN_W-1:0] gain_dec [NUM_GAINS];
  logic [STEP_W-1:0]        step_r   [NUM_GAINS];

  logic [SUM_WIDTH-1:0] wsum_r;
  logic [SUM_WIDTH-1:0] wsum_nxt;
  logic [SUM_WIDTH-1:0] best_r;
  logic [SUM_WIDTH-1:0] best_nxt;
  logic [SUM_WIDTH:0]   acc;
  logic [SUM_WIDTH-1:0] sum_new;
  logic                 better;
  logic [1:0]           trial_r;
  logic [1:0]           trial_nxt;
  logic [1:0]           next_gain;
  phase_t               phase_r;
  phase_t               phase_nxt;

  logic                 sc_start;
  logic                 sc_up;
  step_wb_t             sc_wb;

  logic [OUT_SUM_W-1:0] best_out;

  logic signed [GAIN_W-1:0] out_gain_r [NUM_GAINS];
  logic                     out_valid_r;
  logic                     out_end_r;
  logic [OUT_SUM_W-1:0]     out_best_r;
  logic [1:0]               out_index_r;
  phase_t                   out_phase_r;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // saturating window accumulate
  assign acc     = {1'b0, wsum_r} + (SUM_WIDTH + 1)'(q_item.sq);
  assign sum_new = acc[SUM_WIDTH] ? '1 : acc[SUM_WIDTH-1:0];
  assign better  = sum_new < best_r;

  assign next_gain = (trial_r == GAIN_D) ? GAIN_P : trial_r + 2'd1;

  always_comb begin
    for (int k = 0; k < NUM_GAINS; k++) begin
      gain_inc[k] = sat_add(gain_r[k], {3'b000, step_r[k]});
      gain_dec[k] = sat_add(gain_r[k], -{2'b00, step_r[k], 1'b0});
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_GAINS; k++) begin
      gain_nxt[k] = gain_r[k];
    end
    wsum_nxt  = wsum_r;
    best_nxt  = best_r;
    trial_nxt = trial_r;
    phase_nxt = phase_r;
    sc_start  = 1'b0;
    sc_up     = 1'b0;
    if (q_pop) begin
      if (!q_item.win_end) begin
        wsum_nxt = sum_new;
      end else begin
        wsum_nxt = '0;
        priority if (phase_r == PH_FIRST) begin
          best_nxt         = sum_new;
          trial_nxt        = GAIN_P;
          gain_nxt[GAIN_P] = gain_inc[GAIN_P];
          phase_nxt        = PH_PLUS;
        end else if (phase_r == PH_MINUS) begin
          sc_start = 1'b1;
          if (better) begin
            best_nxt = sum_new;
            sc_up    = 1'b1;
          end else begin
            gain_nxt[trial_r] = gain_inc[trial_r];
          end
          trial_nxt           = next_gain;
          gain_nxt[next_gain] = gain_inc[next_gain];
          phase_nxt           = PH_PLUS;
        end else begin
          if (better) begin
            best_nxt            = sum_new;
            sc_start            = 1'b1;
            sc_up               = 1'b1;
            trial_nxt           = next_gain;
            gain_nxt[next_gain] = gain_inc[next_gain];
            phase_nxt           = PH_PLUS;
          end else begin
            gain_nxt[trial_r] = gain_dec[trial_r];
            phase_nxt         = PH_MINUS;
          end
        end
      end
    end
    // a register write loads the live gain directly
    if (cfg_ld.valid && !cfg_ld.is_step) begin
      gain_nxt[cfg_ld.idx] = cfg_ld.value;
    end
  end

  // scaled step is registered in the scaler, then written; that gain is not read before then
  pgtt_scaler u_scaler (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .idx   (trial_r),
    .up    (sc_up),
    .step  (step_r[trial_r]),
    .wb    (sc_wb)
  );

  generate
    if (SUM_WIDTH > OUT_SUM_W) begin : g_clip
      assign best_out = (|best_nxt[SUM_WIDTH-1:OUT_SUM_W]) ? '1 : best_nxt[OUT_SUM_W-1:0];
    end else begin : g_ext
      assign best_out = OUT_SUM_W'(best_nxt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r[GAIN_P] <= KP_RESET;
      gain_r[GAIN_I] <= KI_RESET;
      gain_r[GAIN_D] <= KD_RESET;
      step_r[GAIN_P] <= STEP_P_RESET;
      step_r[GAIN_I] <= STEP_I_RESET;
      step_r[GAIN_D] <= STEP_D_RESET;
      wsum_r         <= '0;
      best_r         <= '0;
      trial_r        <= GAIN_P;
      phase_r        <= PH_FIRST;
    end else begin
      for (int k = 0; k < NUM_GAINS; k++) begin
        gain_r[k] <= gain_nxt[k];
      end
      wsum_r  <= wsum_nxt;
      best_r  <= best_nxt;
      trial_r <= trial_nxt;
      phase_r <= phase_nxt;
      // a register write overrides any scaled step still in flight
      if (cfg_ld.valid && cfg_ld.is_step) begin
        step_r[cfg_ld.idx] <= cfg_ld.value[STEP_W-1:0];
      end else if (sc_wb.valid) begin
        step_r[sc_wb.idx] <= sc_wb.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < NUM_GAINS; k++) begin
        out_gain_r[k] <= gain_nxt[k];
      end
      out_end_r   <= q_item.win_end;
      out_best_r  <= best_out;
      out_index_r <= trial_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_gain_p      = out_gain_r[GAIN_P];
  assign out_gain_i      = out_gain_r[GAIN_I];
  assign out_gain_d      = out_gain_r[GAIN_D];
  assign out_window_end  = out_end_r;
  assign out_best_error  = out_best_r;
  assign out_gain_index  = out_index_r;
  assign out_trial_phase = out_phase_r;

endmodule

// ===== rtl/pid_gain_twiddle_tuner.sv =====
// twiddle tuner for the three gains of a pid steering loop
//
// input channel (in_valid / in_ready / in_track_error): one signed q8.8
// cross-track error per control tick. result channel (out_valid /
// out_ready / out_*): one transaction per input transaction, in order,
// carrying the three q8.24 gains after that tick, the window-end flag,
// the best window squared-error sum and the gain and phase under trial.
// cfg_* is an apb-style register port, register i at byte address 4*i,
// pready tied high; write only while no transaction is in flight.
// a transaction accepted on in_* passes the queue and the output register
// before it shows on out_*. throughput: one transaction per cycle while
// out_ready is high, set by the accumulate-and-decide loop in the back end.
// reset (rst_n low, synchronous): registers return to their defaults,
// gains and steps reload from them, window sum, best sum, tick count
// and trial state clear, both channels go empty.
// receiver stall: the output register holds, the two-entry queue
// between front and back fills, then in_ready drops until it drains.
module pid_gain_twiddle_tuner #(
  parameter int SUM_WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_track_error,

  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_gain_p,
  output logic signed [31:0]  out_gain_i,
  output logic signed [31:0]  out_gain_d,
  output logic                out_window_end,
  output logic [47:0]         out_best_error,
  output logic [1:0]          out_gain_index,
  output logic [1:0]          out_trial_phase,

  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import pgtt_pkg::*;

  // register file
  logic [TICK_W-1:0]         wl_r;
  logic signed [GAIN_W-1:0]  kp_r;
  logic signed [GAIN_W-1:0]  ki_r;
  logic signed [GAIN_W-1:0]  kd_r;
  logic [STEP_W-1:0]         sp_r;
  logic [STEP_W-1:0]         si_r;
  logic [STEP_W-1:0]         sd_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  cfg_load_t  cfg_ld;

  // front/back link
  logic  q_full;
  logic  q_push;
  item_t q_in;
  logic  q_pop;
  logic  q_valid;
  item_t q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= WL_RESET;
      kp_r <= KP_RESET;
      ki_r <= KI_RESET;
      kd_r <= KD_RESET;
      sp_r <= STEP_P_RESET;
      si_r <= STEP_I_RESET;
      sd_r <= STEP_D_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WINDOW_LENGTH:  wl_r <= cfg_pwdata[TICK_W-1:0];
        REG_INITIAL_KP:     kp_r <= cfg_pwdata;
        REG_INITIAL_KI:     ki_r <= cfg_pwdata;
        REG_INITIAL_KD:     kd_r <= cfg_pwdata;
        REG_INITIAL_STEP_P: sp_r <= cfg_pwdata[STEP_W-1:0];
        REG_INITIAL_STEP_I: si_r <= cfg_pwdata[STEP_W-1:0];
        REG_INITIAL_STEP_D: sd_r <= cfg_pwdata[STEP_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WINDOW_LENGTH:  cfg_prdata = 32'(wl_r);
      REG_INITIAL_KP:     cfg_prdata = kp_r;
      REG_INITIAL_KI:     cfg_prdata = ki_r;
      REG_INITIAL_KD:     cfg_prdata = kd_r;
      REG_INITIAL_STEP_P: cfg_prdata = 32'(sp_r);
      REG_INITIAL_STEP_I: cfg_prdata = 32'(si_r);
      REG_INITIAL_STEP_D: cfg_prdata = 32'(sd_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // writing an initial gain or step also loads the live copy in the back end
  always_comb begin
    cfg_ld.valid   = 1'b0;
    cfg_ld.is_step = 1'b0;
    cfg_ld.idx     = GAIN_P;
    cfg_ld.value   = cfg_pwdata;
    unique case (cfg_idx)
      REG_INITIAL_KP: begin
        cfg_ld.valid = cfg_wr;
        cfg_ld.idx   = GAIN_P;
      end
      REG_INITIAL_KI: begin
        cfg_ld.valid = cfg_wr;
        cfg_ld.idx   = GAIN_I;
      end
      REG_INITIAL_KD: begin
        cfg_ld.valid = cfg_wr;
        cfg_ld.idx   = GAIN_D;
      end
      REG_INITIAL_STEP_P: begin
        cfg_ld.valid   = cfg_wr;
        cfg_ld.is_step = 1'b1;
        cfg_ld.idx     = GAIN_P;
      end
      REG_INITIAL_STEP_I: begin
        cfg_ld.valid   = cfg_wr;
        cfg_ld.is_step = 1'b1;
        cfg_ld.idx     = GAIN_I;
      end
      REG_INITIAL_STEP_D: begin
        cfg_ld.valid   = cfg_wr;
        cfg_ld.is_step = 1'b1;
        cfg_ld.idx     = GAIN_D;
      end
      default: ;  // window length and unmapped addresses load nothing live
    endcase
  end

  // front: squares the sample and marks the tick that closes a window
  pgtt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_track_error (in_track_error),
    .window_length  (wl_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  // two-entry queue lets the front take two more samples while out_* stalls
  pgtt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  // back: window sum, twiddle decision, gain/step state, output register
  pgtt_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_head),
    .q_pop           (q_pop),
    .cfg_ld          (cfg_ld),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_gain_p      (out_gain_p),
    .out_gain_i      (out_gain_i),
    .out_gain_d      (out_gain_d),
    .out_window_end  (out_window_end),
    .out_best_error  (out_best_error),
    .out_gain_index  (out_gain_index),
    .out_trial_phase (out_trial_phase)
  );

endmodule

// ===== rtl/pgtt_checker.sv =====
module pgtt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [31:0]  out_gain_p,
  input logic                out_window_end,
  input logic [47:0]         out_best_error,
  input logic [1:0]          out_gain_index,
  input logic [1:0]          out_trial_phase
);
  import pgtt_pkg::*;

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gain_p)
      && $stable(out_best_error) && $stable(out_trial_phase))
    else $error("stalled result changed");

  // a decision always leaves the search in a plus or minus trial
  a_decision_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_end |->
      (out_trial_phase == PH_PLUS || out_trial_phase == PH_MINUS))
    else $error("decision reported first-window phase");

  // before the first decision nothing has been scored or tried
  a_first_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trial_phase == PH_FIRST |->
      out_best_error == '0 && out_gain_index == GAIN_P)
    else $error("first window shows a best error or trial gain");

endmodule

bind pid_gain_twiddle_tuner pgtt_checker u_pgtt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_gain_p      (out_gain_p),
  .out_window_end  (out_window_end),
  .out_best_error  (out_best_error),
  .out_gain_index  (out_gain_index),
  .out_trial_phase (out_trial_phase)
);

// ===== verif/testbench.sv =====
module testbench;
  import pgtt_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 3;      // idle wait after the last owed report is back
  localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up
  localparam int LONG_HOLD      = 150;    // receiver back-pressure stretch
  localparam int MAX_SHOWN      = 10;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_TICKS    = 104;
  localparam int HOLD_PHASE     = 2;
  localparam int ZERO_WIN_TICKS = 40;     // ticks run with the window length at zero
  localparam int STEP_GROW      = 11;     // step * 1.1 in tenths
  localparam int STEP_SHRINK    = 9;      // step * 0.9 in tenths

  localparam logic [2:0]  REG_UNUSED = 3'd7;  // decodes to nothing
  localparam logic [47:0] SUM_MAX    = '1;
  localparam longint      GAIN_HI    = 2147483647;
  localparam longint      GAIN_LO    = -GAIN_HI - 1;

  // one gain report, as the result channel carries it
  typedef struct {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic                     window_end;
    logic [OUT_SUM_W-1:0]     best_error;
    logic [1:0]               gain_index;
    phase_t                   trial_phase;
  } gain_report_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_ready;
  logic signed [15:0]       in_track_error;

  logic                     out_valid;
  logic                     out_ready;
  logic signed [GAIN_W-1:0] out_gain_p;
  logic signed [GAIN_W-1:0] out_gain_i;
  logic signed [GAIN_W-1:0] out_gain_d;
  logic                     out_window_end;
  logic [OUT_SUM_W-1:0]     out_best_error;
  logic [1:0]               out_gain_index;
  logic [1:0]               out_trial_phase;

  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [ADDR_W-1:0]        cfg_paddr;
  logic [CFG_W-1:0]         cfg_pwdata;
  logic [CFG_W-1:0]         cfg_prdata;
  logic                     cfg_pready;

  // tuner state as the testbench tracks it
  logic [TICK_W-1:0]        win_len;
  logic signed [GAIN_W-1:0] live_gain [NUM_GAINS];
  logic [STEP_W-1:0]        live_step [NUM_GAINS];
  logic [OUT_SUM_W-1:0]     err_sum;
  logic [OUT_SUM_W-1:0]     best_sum;
  logic [TICK_W-1:0]        tick_count;
  logic                     first_done;
  logic [1:0]               trial_gain;
  phase_t                   trial_ph;

  // gain reports still owed by the block, oldest first
  gain_report_t gain_report_q [$];

  // idling controls
  bit gaps_on;
  bit stalls_on;
  bit hold_req;

  int ticks_sent;
  int reports_checked;
  int decisions_seen;
  int bad_reports;
  int cfg_writes;

  pid_gain_twiddle_tuner u_top (.*);

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // twiddle arithmetic
  // ---------------------------------------------------------------------------

  // gain plus mult*step, clamped to the signed 32-bit range
  function automatic logic signed [GAIN_W-1:0] shift_gain(logic signed [GAIN_W-1:0] g,
                                                          logic [STEP_W-1:0] s, int mult);
    longint v;
    longint d;
    d = s;
    v = longint'(g) + mult * d;
    if (v > GAIN_HI) return GAIN_HI[GAIN_W-1:0];
    if (v < GAIN_LO) return GAIN_LO[GAIN_W-1:0];
    return v[GAIN_W-1:0];
  endfunction

  // step * tenths / 10, nearest with ties up, clamped to 31 bits
  function automatic logic [STEP_W-1:0] scale_step(logic [STEP_W-1:0] s, int unsigned tenths);
    longint unsigned r;
    r = s;
    r = (r * tenths + 5) / 10;
    if (r > STEP_MAX) return STEP_MAX;
    return r[STEP_W-1:0];
  endfunction

  // rotate to the next gain and try its plus side
  function automatic void advance_gain();
    trial_gain = (trial_gain == GAIN_D) ? GAIN_P : trial_gain + 2'd1;
    live_gain[trial_gain] = shift_gain(live_gain[trial_gain], live_step[trial_gain], 1);
    trial_ph = PH_PLUS;
  endfunction

  // one control tick: accumulate the squared error, decide at window end
  function automatic gain_report_t twiddle_tick(logic signed [15:0] err);
    longint unsigned sq;
    longint unsigned room;
    logic [1:0]      g;
    gain_report_t    rep;
    sq   = longint'(err) * longint'(err);
    room = SUM_MAX - err_sum;
    err_sum = (sq > room) ? SUM_MAX : err_sum + sq;
    rep.window_end = 1'b0;
    if (win_len != 0 && tick_count >= win_len) begin
      g = trial_gain;
      if (!first_done) begin
        // first window only sets the reference
        best_sum   = err_sum;
        first_done = 1'b1;
        trial_gain = GAIN_P;
        live_gain[GAIN_P] = shift_gain(live_gain[GAIN_P], live_step[GAIN_P], 1);
        trial_ph   = PH_PLUS;
      end else if (err_sum < best_sum) begin
        // improvement on either side: keep the gain, widen the step
        best_sum = err_sum;
        live_step[g] = scale_step(live_step[g], STEP_GROW);
        advance_gain();
      end else if (trial_ph == PH_MINUS) begin
        // both sides lost: put the gain back, narrow the step
        live_gain[g] = shift_gain(live_gain[g], live_step[g], 1);
        live_step[g] = scale_step(live_step[g], STEP_SHRINK);
        advance_gain();
      end else begin
        live_gain[g] = shift_gain(live_gain[g], live_step[g], -2);
        trial_ph = PH_MINUS;
      end
      err_sum        = '0;
      tick_count     = TICK_W'(1);
      rep.window_end = 1'b1;
    end else if (tick_count < TICK_MAX) begin
      tick_count++;
    end
    rep.gain_p      = live_gain[GAIN_P];
    rep.gain_i      = live_gain[GAIN_I];
    rep.gain_d      = live_gain[GAIN_D];
    rep.best_error  = best_sum;
    rep.gain_index  = trial_gain;
    rep.trial_phase = trial_ph;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // offer one error sample; valid is left high for a back-to-back transaction
  task automatic send_error(logic signed [15:0] err);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_track_error <= err;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gain_report_q.push_back(twiddle_tick(err));
    ticks_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every owed report is back
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (gain_report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // setup then access phase, then idle so writes never touch
  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    // initial gain and step registers load the live values at once
    case (idx)
      REG_WINDOW_LENGTH:  win_len           = val[TICK_W-1:0];
      REG_INITIAL_KP:     live_gain[GAIN_P] = val;
      REG_INITIAL_KI:     live_gain[GAIN_I] = val;
      REG_INITIAL_KD:     live_gain[GAIN_D] = val;
      REG_INITIAL_STEP_P: live_step[GAIN_P] = val[STEP_W-1:0];
      REG_INITIAL_STEP_I: live_step[GAIN_I] = val[STEP_W-1:0];
      REG_INITIAL_STEP_D: live_step[GAIN_D] = val[STEP_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // window length in the low half, junk above it
  task automatic write_window(logic [TICK_W-1:0] len);
    logic [CFG_W-1:0] word;
    word = $urandom;
    word[TICK_W-1:0] = len;
    write_reg(REG_WINDOW_LENGTH, word);
  endtask

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // bit 31 is random throughout, the block must drop it
  function automatic logic [CFG_W-1:0] pick_step();
    logic [CFG_W-1:0] top;
    top = {1'($urandom_range(0, 1)), 31'd0};
    case ($urandom_range(0, 5))
      0: return top | {1'b0, STEP_MAX};
      1: return top;
      2: return $urandom;
      default: return top | $urandom_range(0, 1 << 26);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random ready bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // report checker: each accepted transaction against the oldest owed report
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : report_check
    gain_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (gain_report_q.size() == 0) begin
        bad_reports++;
        if (bad_reports <= MAX_SHOWN)
          $display("unexpected gain report: p=%0d i=%0d d=%0d end=%0b",
                   out_gain_p, out_gain_i, out_gain_d, out_window_end);
      end else begin
        want = gain_report_q.pop_front();
        reports_checked++;
        if (out_window_end) decisions_seen++;
        if (out_gain_p !== want.gain_p || out_gain_i !== want.gain_i ||
            out_gain_d !== want.gain_d || out_window_end !== want.window_end ||
            out_best_error !== want.best_error || out_gain_index !== want.gain_index ||
            out_trial_phase !== want.trial_phase) begin
          bad_reports++;
          if (bad_reports <= MAX_SHOWN) begin
            $display("report %0d expected: p=%0d i=%0d d=%0d end=%0b best=%0d idx=%0d ph=%0d",
                     reports_checked, want.gain_p, want.gain_i, want.gain_d,
                     want.window_end, want.best_error, want.gain_index, want.trial_phase);
            $display("report %0d actual:   p=%0d i=%0d d=%0d end=%0b best=%0d idx=%0d ph=%0d",
                     reports_checked, out_gain_p, out_gain_i, out_gain_d,
                     out_window_end, out_best_error, out_gain_index, out_trial_phase);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run after too many cycles with no transaction at all
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset gains at the outputs; the first window holds one extra sample,
  // so the first decision lands on the 51st tick at the default length
  task automatic test_reset_and_first_window();
    for (int n = 0; n <= int'(WL_RESET); n++)
      send_error((n % 2) ? 16'sh7FFF : 16'sh8000);
  endtask

  // zero window length: no decision however long the window runs,
  // then a length under the running count decides on the next tick
  task automatic test_zero_window();
    drain_reports();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_window('0);
    repeat (ZERO_WIN_TICKS) send_error(16'sh8000);
    drain_reports();
    write_window(16'd1);
    send_error(16'sh8000);
  endtask

  // gains at both rails, steps at max: adds past a rail clamp, step * 1.1 clamps
  task automatic test_gain_saturation();
    logic signed [15:0] errs [6] = '{20000, 19000, 30000, 25000, 25000, 18000};
    drain_reports();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_reg(REG_INITIAL_KP, 32'h7FFF_FFFF);
    write_reg(REG_INITIAL_KI, 32'h8000_0000);
    write_reg(REG_INITIAL_KD, 32'h7FFF_FFFF);
    write_reg(REG_INITIAL_STEP_P, 32'hFFFF_FFFF);
    write_reg(REG_INITIAL_STEP_I, 32'hFFFF_FFFF);
    write_reg(REG_INITIAL_STEP_D, {1'b0, STEP_MAX});
    foreach (errs[k]) send_error(errs[k]);
  endtask

  // tiny steps show rounding with ties up; equal sums are not better
  task automatic test_step_rounding();
    logic signed [15:0] errs [6] = '{16000, 16000, 15000, 15500, -14500, 14500};
    drain_reports();
    write_reg(REG_INITIAL_KP, 32'h0100_0000);
    write_reg(REG_INITIAL_KI, 32'hFF00_0000);
    write_reg(REG_INITIAL_KD, '0);
    write_reg(REG_INITIAL_STEP_P, '0);
    write_reg(REG_INITIAL_STEP_I, 32'd1);
    write_reg(REG_INITIAL_STEP_D, 32'd5);
    foreach (errs[k]) send_error(errs[k]);
  endtask

  // longest window, then a length under the running count: decide next tick
  task automatic test_window_lowered();
    drain_reports();
    write_window(TICK_MAX);
    send_error(16'sd14200);
    send_error(-16'sd14300);
    send_error(16'sd14400);
    drain_reports();
    write_window(16'd2);
    send_error(16'sd14100);
    send_error(-16'sd14050);
  endtask

  // a write past the last register changes nothing
  task automatic test_unused_register();
    drain_reports();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_error(16'sd14000);
  endtask

  // phases of random settings; errors mostly follow a slowly falling level
  // so improvements keep coming, the rest is full-range noise
  task automatic test_random_tuning();
    int          ph;
    int unsigned level;
    int unsigned mag;
    logic signed [15:0] err;
    level = 13000;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      // the pause before each phase waits out every owed report
      drain_reports();
      gaps_on   = (ph < RANDOM_PHASES - 2);
      stalls_on = (ph < RANDOM_PHASES - 2);
      case (ph)
        0:       write_window(16'd1);
        4:       write_window(TICK_MAX);
        7:       write_window('0);
        default: write_window(($urandom_range(0, 5) == 0) ? WL_RESET : $urandom_range(1, 5));
      endcase
      if ($urandom_range(0, 1)) write_reg(REG_INITIAL_KP, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_INITIAL_KI, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_INITIAL_KD, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_INITIAL_STEP_P, pick_step());
      if ($urandom_range(0, 1)) write_reg(REG_INITIAL_STEP_I, pick_step());
      if ($urandom_range(0, 1)) write_reg(REG_INITIAL_STEP_D, pick_step());
      // hold the receiver while the sender keeps going: the block backs up
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      repeat (PHASE_TICKS) begin
        case ($urandom_range(0, 7))
          0:       err = 16'sh8000;
          1:       err = 16'sh7FFF;
          2:       err = $urandom;
          default: begin
            mag = level - $urandom_range(0, level / 4);
            err = $urandom_range(0, 1) ? -$signed(16'(mag)) : $signed(16'(mag));
          end
        endcase
        send_error(err);
        if (level > 1200) level -= 8;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_track_error = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    hold_req       = 1'b0;

    // tracked state starts from the register defaults
    win_len            = WL_RESET;
    live_gain[GAIN_P]  = KP_RESET;
    live_gain[GAIN_I]  = KI_RESET;
    live_gain[GAIN_D]  = KD_RESET;
    live_step[GAIN_P]  = STEP_P_RESET;
    live_step[GAIN_I]  = STEP_I_RESET;
    live_step[GAIN_D]  = STEP_D_RESET;
    err_sum            = '0;
    best_sum           = '0;
    tick_count         = '0;
    first_done         = 1'b0;
    trial_gain         = GAIN_P;
    trial_ph           = PH_FIRST;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_and_first_window();
    test_zero_window();
    test_gain_saturation();
    test_step_rounding();
    test_window_lowered();
    test_unused_register();
    test_random_tuning();
    drain_reports();

    if (gain_report_q.size() != 0) begin
      bad_reports++;
      $display("%0d gain reports never arrived", gain_report_q.size());
    end
    $display("tuner run: %0d error transactions, %0d gain reports checked, %0d decisions",
             ticks_sent, reports_checked, decisions_seen);
    $display("%0d register writes over window lengths 0 to 65535, railed gains and steps; %0d bad",
             cfg_writes, bad_reports);
    if (bad_reports == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== pid_gain_twiddle_tuner.f =====
rtl/pgtt_pkg.sv
rtl/pgtt_front.sv
rtl/pgtt_queue.sv
rtl/pgtt_scaler.sv
rtl/pgtt_back.sv
rtl/pid_gain_twiddle_tuner.sv
rtl/pgtt_checker.sv
verif/testbench.sv
